/* hw/rtl/law_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_pkg
// Shared widths, codes, types and helpers of the lattice aggregation walker.
// ----------------------------------------------------------------------------
package law_pkg;

  localparam int COORD_W    = 8;
  localparam int ACTION_W   = 2;
  localparam int DIR_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int STEP_W     = 21;
  localparam int COUNT_W    = 17;
  localparam int SUM_W      = 24;
  localparam int SQSUM_W    = 33;
  localparam int RAD_W      = 17;
  localparam int GYR_W      = 49;
  localparam int CSQ_W      = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 120;

  localparam logic [STEP_W-1:0]  STEP_MAX  = {STEP_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_CAP = 17'd65536;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_PLANT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LAUNCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP   = 2'd2;

  // step directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_MOVED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STUCK  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_KILLED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_TRCK = 2'd3;

  localparam logic [COORD_W-1:0] CENTER_X_RST   = 8'd128;
  localparam logic [COORD_W-1:0] CENTER_Y_RST   = 8'd128;
  localparam logic [STEP_W-1:0]  STEP_LIMIT_RST = 21'd65536;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [STEP_W-1:0]  step_limit;
    logic               radius_tracking;
    logic [CSQ_W-1:0]   center_sq;
  } cfg_t;

  // result fields that pass straight through the statistics pipeline
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [STEP_W-1:0]   steps;
    logic [COUNT_W-1:0]  count;
    logic [RAD_W-1:0]    rad;
  } fld_t;

  typedef struct packed {
    fld_t               fld;
    logic [SUM_W-1:0]   sum_col;
    logic [SUM_W-1:0]   sum_row;
    logic [SQSUM_W-1:0] sum_sq;
  } res_t;

  typedef struct packed {
    fld_t             fld;
    logic [GYR_W-1:0] gyr;
  } out_t;

  function automatic logic [2*COORD_W-1:0] sq8(input logic [COORD_W-1:0] v);
    return {{COORD_W{1'b0}}, v} * {{COORD_W{1'b0}}, v};
  endfunction

endpackage

/* hw/rtl/law_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_bank
// One bank of the occupancy bitmap: a row per word, two registered read
// ports, a single-bit set port and a whole-row clear port.
// ----------------------------------------------------------------------------
module law_bank #(
  parameter int ROW_AW = 7,
  parameter int COLS   = 256
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [ROW_AW-1:0]       rd_addr_a,
  input  logic [ROW_AW-1:0]       rd_addr_b,
  output logic [COLS-1:0]         rd_row_a,
  output logic [COLS-1:0]         rd_row_b,
  input  logic                    set_en,
  input  logic [ROW_AW-1:0]       set_addr,
  input  logic [$clog2(COLS)-1:0] set_bit,
  input  logic                    clr_en,
  input  logic [ROW_AW-1:0]       clr_addr
);

  logic [COLS-1:0] mem_r [2**ROW_AW];

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem_r[clr_addr] <= '0;
    end else if (set_en) begin
      mem_r[set_addr][set_bit] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_a <= mem_r[rd_addr_a];
      rd_row_b <= mem_r[rd_addr_b];
    end
  end

endmodule

/* hw/rtl/law_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_core
// Walker state and bitmap access: reads the neighbour rows on transfer,
// resolves the item from the registered rows once its result is taken, and writes marked cells back.
// ----------------------------------------------------------------------------
module law_core #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  output logic                             in_rdy,
  input  logic [law_pkg::ACTION_W-1:0]     in_action,
  input  logic [law_pkg::COORD_W-1:0]      in_x,
  input  logic [law_pkg::COORD_W-1:0]      in_y,
  input  logic [law_pkg::DIR_W-1:0]        in_dir,
  input  law_pkg::cfg_t                    cfg,
  output logic                             res_vld,
  input  logic                             res_rdy,
  output law_pkg::res_t                    res
);

  localparam int LAT_W    = (GRID_WIDTH < 256) ? GRID_WIDTH : 256;
  localparam int LAT_H    = (GRID_HEIGHT < 256) ? GRID_HEIGHT : 256;
  localparam int HALF_MIN = ((GRID_WIDTH > GRID_HEIGHT) ? GRID_HEIGHT : GRID_WIDTH) / 2;
  localparam int RAD_LIM  = HALF_MIN * HALF_MIN;
  localparam int COL_AW   = $clog2(LAT_W);
  localparam int ROW_AW   = $clog2((LAT_H + 1) / 2);
  localparam logic [law_pkg::COORD_W-1:0] X_LAST = law_pkg::COORD_W'(LAT_W - 1);
  localparam logic [law_pkg::COORD_W-1:0] Y_LAST = law_pkg::COORD_W'(LAT_H - 1);

  typedef enum logic [1:0] {K_NONE, K_PLANT, K_LAUNCH, K_STEP} kind_t;

  // walker and cluster state
  logic [law_pkg::COORD_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic [law_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic                        active_r, active_nxt;
  logic [law_pkg::COUNT_W-1:0] stuck_r, stuck_nxt;
  logic [law_pkg::SUM_W-1:0]   scol_r, scol_nxt, srow_r, srow_nxt;
  logic [law_pkg::SQSUM_W-1:0] ssq_r, ssq_nxt;
  logic [law_pkg::RAD_W-1:0]   rad_r, rad_nxt;

  // item held between the bitmap read and its resolution
  logic                        s1_vld_r;
  kind_t                       s1_kind_r;
  logic [law_pkg::COORD_W-1:0] s1_x_r, s1_y_r;
  logic                        s1_off_r;
  logic                        s1_mu_r, s1_md_r, s1_ml_r, s1_mr_r;
  logic [law_pkg::RAD_W-1:0]   s1_d2_r;
  logic [law_pkg::RAD_W-1:0]   s1_sq_r;

  // clearing pass
  logic              clr_r;
  logic [ROW_AW-1:0] clr_row_r;

  // transfer side
  logic                        acc;
  logic                        in_rng;
  kind_t                       kind;
  logic [law_pkg::COORD_W-1:0] nx, ny, tx, ty, up_row, dn_row, adx, ady;
  logic                        off;
  logic [law_pkg::RAD_W-1:0]   d2, sq_xy;

  // bank ports
  logic [ROW_AW-1:0] b0_ra, b0_rb, b1_ra, b1_rb, wr_addr;
  logic [LAT_W-1:0]  b0_qa, b0_qb, b1_qa, b1_qb;
  logic [LAT_W-1:0]  row_c, row_u, row_d;
  logic [COL_AW-1:0] xi, xl, xr;
  logic              nb, fire, mem_we, stick;
  logic [law_pkg::STEP_W-1:0]   steps_inc;
  logic [law_pkg::STATUS_W-1:0] status;

  assign in_rdy = !s1_vld_r && !clr_r;
  assign acc    = in_vld && in_rdy;

  always_comb begin
    nx  = wx_r;
    ny  = wy_r;
    off = 1'b0;
    case (in_dir)
      law_pkg::DIR_UP: begin
        ny  = wy_r - 1'b1;
        off = (wy_r == '0);
      end
      law_pkg::DIR_RIGHT: begin
        nx  = wx_r + 1'b1;
        off = (wx_r == X_LAST);
      end
      law_pkg::DIR_DOWN: begin
        ny  = wy_r + 1'b1;
        off = (wy_r == Y_LAST);
      end
      default: begin
        nx  = wx_r - 1'b1;
        off = (wx_r == '0);
      end
    endcase
  end

  assign in_rng = (in_x <= X_LAST) && (in_y <= Y_LAST);

  always_comb begin
    case (in_action)
      law_pkg::ACT_PLANT:  kind = in_rng ? K_PLANT : K_NONE;
      law_pkg::ACT_LAUNCH: kind = in_rng ? K_LAUNCH : K_NONE;
      law_pkg::ACT_STEP:   kind = active_r ? K_STEP : K_NONE;
      default:             kind = K_NONE;
    endcase
  end

  assign tx = (kind == K_STEP) ? nx : in_x;
  assign ty = (kind == K_STEP) ? ny : in_y;

  assign adx   = (tx >= cfg.center_x) ? tx - cfg.center_x : cfg.center_x - tx;
  assign ady   = (ty >= cfg.center_y) ? ty - cfg.center_y : cfg.center_y - ty;
  assign d2    = {1'b0, law_pkg::sq8(adx)} + {1'b0, law_pkg::sq8(ady)};
  assign sq_xy = {1'b0, law_pkg::sq8(tx)} + {1'b0, law_pkg::sq8(ty)};

  // rows above and below share a parity, so they sit in the other bank
  assign up_row = ty - 1'b1;
  assign dn_row = ty + 1'b1;
  assign b0_ra  = ty[0] ? up_row[ROW_AW:1] : ty[ROW_AW:1];
  assign b1_ra  = ty[0] ? ty[ROW_AW:1] : up_row[ROW_AW:1];
  assign b0_rb  = dn_row[ROW_AW:1];
  assign b1_rb  = dn_row[ROW_AW:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (acc) begin
      s1_vld_r <= 1'b1;
    end else if (fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r <= kind;
      s1_x_r    <= tx;
      s1_y_r    <= ty;
      s1_off_r  <= off;
      s1_mu_r   <= (ty != '0);
      s1_md_r   <= (ty != Y_LAST);
      s1_ml_r   <= (tx != '0);
      s1_mr_r   <= (tx != X_LAST);
      s1_d2_r   <= d2;
      s1_sq_r   <= sq_xy;
    end
  end

  // resolution
  assign fire  = s1_vld_r && res_rdy;
  assign row_c = s1_y_r[0] ? b1_qa : b0_qa;
  assign row_u = s1_y_r[0] ? b0_qa : b1_qa;
  assign row_d = s1_y_r[0] ? b0_qb : b1_qb;
  assign xi    = s1_x_r[COL_AW-1:0];
  assign xl    = xi - 1'b1;
  assign xr    = xi + 1'b1;
  assign nb    = (s1_mu_r && row_u[xi]) || (s1_md_r && row_d[xi]) ||
                 (s1_ml_r && row_c[xl]) || (s1_mr_r && row_c[xr]);

  assign steps_inc = (steps_r == law_pkg::STEP_MAX) ? steps_r : steps_r + 1'b1;

  always_comb begin
    wx_nxt     = wx_r;
    wy_nxt     = wy_r;
    steps_nxt  = steps_r;
    active_nxt = active_r;
    stuck_nxt  = stuck_r;
    scol_nxt   = scol_r;
    srow_nxt   = srow_r;
    ssq_nxt    = ssq_r;
    rad_nxt    = rad_r;
    status     = law_pkg::ST_OUT;
    stick      = 1'b0;
    mem_we     = 1'b0;
    case (s1_kind_r)
      K_PLANT: begin
        mem_we = 1'b1;
        status = law_pkg::ST_ACCEPT;
      end
      K_LAUNCH: begin
        wx_nxt     = s1_x_r;
        wy_nxt     = s1_y_r;
        steps_nxt  = '0;
        active_nxt = 1'b1;
        status     = law_pkg::ST_ACCEPT;
      end
      K_STEP: begin
        steps_nxt = steps_inc;
        if (s1_off_r) begin
          active_nxt = 1'b0;
          status     = law_pkg::ST_OUT;
        end else if (nb) begin
          stick      = 1'b1;
          mem_we     = 1'b1;
          wx_nxt     = s1_x_r;
          wy_nxt     = s1_y_r;
          active_nxt = 1'b0;
          status     = law_pkg::ST_STUCK;
        end else if (steps_inc >= cfg.step_limit) begin
          active_nxt = 1'b0;
          status     = law_pkg::ST_KILLED;
        end else begin
          wx_nxt = s1_x_r;
          wy_nxt = s1_y_r;
          status = law_pkg::ST_MOVED;
        end
      end
      default: begin
        status = law_pkg::ST_OUT;
      end
    endcase
    if (stick) begin
      if (stuck_r < law_pkg::COUNT_CAP) begin
        stuck_nxt = stuck_r + 1'b1;
        scol_nxt  = scol_r + law_pkg::SUM_W'(s1_x_r);
        srow_nxt  = srow_r + law_pkg::SUM_W'(s1_y_r);
        ssq_nxt   = ssq_r + law_pkg::SQSUM_W'(s1_sq_r);
      end
      if (cfg.radius_tracking && (32'(rad_r) < RAD_LIM) && (s1_d2_r > rad_r)) begin
        rad_nxt = s1_d2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r     <= '0;
      wy_r     <= '0;
      steps_r  <= '0;
      active_r <= 1'b0;
      stuck_r  <= '0;
      scol_r   <= '0;
      srow_r   <= '0;
      ssq_r    <= '0;
      rad_r    <= '0;
    end else if (fire) begin
      wx_r     <= wx_nxt;
      wy_r     <= wy_nxt;
      steps_r  <= steps_nxt;
      active_r <= active_nxt;
      stuck_r  <= stuck_nxt;
      scol_r   <= scol_nxt;
      srow_r   <= srow_nxt;
      ssq_r    <= ssq_nxt;
      rad_r    <= rad_nxt;
    end
  end

  assign res_vld         = s1_vld_r;
  assign res.fld.status  = status;
  assign res.fld.pos_x   = wx_nxt;
  assign res.fld.pos_y   = wy_nxt;
  assign res.fld.steps   = steps_nxt;
  assign res.fld.count   = stuck_nxt;
  assign res.fld.rad     = rad_nxt;
  assign res.sum_col     = scol_nxt;
  assign res.sum_row     = srow_nxt;
  assign res.sum_sq      = ssq_nxt;

  // one row of each bank per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_row_r <= '0;
    end else if (clr_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (clr_row_r == {ROW_AW{1'b1}}) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign wr_addr = s1_y_r[ROW_AW:1];

  law_bank #(
    .ROW_AW (ROW_AW),
    .COLS   (LAT_W)
  ) u_bank0 (
    .clk       (clk),
    .rd_en     (acc),
    .rd_addr_a (b0_ra),
    .rd_addr_b (b0_rb),
    .rd_row_a  (b0_qa),
    .rd_row_b  (b0_qb),
    .set_en    (fire && mem_we && !s1_y_r[0]),
    .set_addr  (wr_addr),
    .set_bit   (xi),
    .clr_en    (clr_r),
    .clr_addr  (clr_row_r)
  );

  law_bank #(
    .ROW_AW (ROW_AW),
    .COLS   (LAT_W)
  ) u_bank1 (
    .clk       (clk),
    .rd_en     (acc),
    .rd_addr_a (b1_ra),
    .rd_addr_b (b1_rb),
    .rd_row_a  (b1_qa),
    .rd_row_b  (b1_qb),
    .set_en    (fire && mem_we && s1_y_r[0]),
    .set_addr  (wr_addr),
    .set_bit   (xi),
    .clr_en    (clr_r),
    .clr_addr  (clr_row_r)
  );

endmodule

/* hw/rtl/law_gyr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// law_gyr
// Statistics pipeline: adds the seed to the running sums, forms the three
// products and the scaled gyration, and holds the result for transfer.
// ----------------------------------------------------------------------------
module law_gyr (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_rdy,
  input  law_pkg::res_t res,
  input  law_pkg::cfg_t cfg,
  output logic          o_vld,
  input  logic          o_rdy,
  output law_pkg::out_t o
);

  localparam int N_W  = law_pkg::COUNT_W;
  localparam int SX_W = law_pkg::SUM_W + 1;
  localparam int SQ_W = law_pkg::SQSUM_W + 1;

  logic          a_vld_r, b_vld_r, c_vld_r, o_vld_r;
  logic          a_free, b_free, c_free, o_free;
  law_pkg::res_t a_r;
  law_pkg::fld_t b_fld_r, c_fld_r;
  law_pkg::out_t o_r;

  logic [N_W-1:0]  b_n_r;
  logic [SX_W-1:0] b_sx_r, b_sy_r;
  logic [SQ_W-1:0] b_sq_r;

  logic [N_W+SQ_W-1:0] p_nsq;
  logic [2*SX_W-1:0]   p_sx, p_sy;
  logic [law_pkg::GYR_W-1:0] c_nsq_r, c_sx_r, c_sy_r;

  assign o_free = !o_vld_r || o_rdy;
  assign c_free = !c_vld_r || o_free;
  assign b_free = !b_vld_r || c_free;
  assign a_free = !a_vld_r || b_free;
  assign in_rdy = a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_r <= in_vld;
      end
      if (b_free) begin
        b_vld_r <= a_vld_r;
      end
      if (c_free) begin
        c_vld_r <= b_vld_r;
      end
      if (o_free) begin
        o_vld_r <= c_vld_r;
      end
    end
  end

  assign p_nsq = b_n_r * b_sq_r;
  assign p_sx  = b_sx_r * b_sx_r;
  assign p_sy  = b_sy_r * b_sy_r;

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_r <= res;
    end
    // seed cell at the centre joins the sums here
    if (b_free) begin
      b_fld_r <= a_r.fld;
      b_n_r   <= a_r.fld.count + 1'b1;
      b_sx_r  <= {1'b0, a_r.sum_col} + SX_W'(cfg.center_x);
      b_sy_r  <= {1'b0, a_r.sum_row} + SX_W'(cfg.center_y);
      b_sq_r  <= {1'b0, a_r.sum_sq} + SQ_W'(cfg.center_sq);
    end
    if (c_free) begin
      c_fld_r <= b_fld_r;
      c_nsq_r <= p_nsq[law_pkg::GYR_W-1:0];
      c_sx_r  <= p_sx[law_pkg::GYR_W-1:0];
      c_sy_r  <= p_sy[law_pkg::GYR_W-1:0];
    end
    if (o_free) begin
      o_r.fld <= c_fld_r;
      o_r.gyr <= c_nsq_r - c_sx_r - c_sy_r;
    end
  end

  assign o_vld = o_vld_r;
  assign o     = o_r;

endmodule

/* hw/rtl/lattice_aggregation_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_aggregation_walker
// Occupancy bitmap with one walker: plants seed cells, launches and steps the
// walker, and reports cluster count, scaled gyration and largest squared distance.
// ----------------------------------------------------------------------------
//  channel  ports               contents (lowest bit first)
//  in       in_t*               tuser: action; tdata: x, y, direction
//  out      out_t*              tuser: status; tdata: pos_x, pos_y,
//                               steps_taken, cluster_count, gyration_scaled,
//                               max_dist_sq
//  cfg      cfg_*               index 0 center_x, 1 center_y, 2 step_limit,
//                               3 radius_tracking
//
//  A new item is taken only after the last one is resolved: the transfer cycle
//  reads three bitmap rows from the two row-parity banks, and the item is
//  resolved and its marked cell written back once the statistics pipeline
//  takes the result, which then passes stages a, b, c and the output register.
//  After reset a clearing pass of one row per bank per cycle keeps in_tready
//  low; configuration writes still land.
//  With out_tready low four results wait in the statistics stages and a fifth
//  item in the core before in_tready stays low.
// ----------------------------------------------------------------------------
module lattice_aggregation_walker #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [law_pkg::IN_TDATA_W-1:0]    in_tdata,   // x, y, direction
  input  logic [law_pkg::ACTION_W-1:0]      in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pos_x, pos_y, steps_taken, cluster_count, gyration_scaled, max_dist_sq
  output logic [law_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [law_pkg::STATUS_W-1:0]      out_tuser,  // status
  input  logic                              cfg_wr_en,
  input  logic [law_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [law_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [law_pkg::COORD_W-1:0] cx_r, cy_r;
  logic [law_pkg::STEP_W-1:0]  lim_r;
  logic                        trk_r;
  logic [law_pkg::CSQ_W-1:0]   csq_r;
  law_pkg::cfg_t               cfg;

  logic          res_vld, res_rdy;
  law_pkg::res_t res;
  law_pkg::out_t o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= law_pkg::CENTER_X_RST;
      cy_r  <= law_pkg::CENTER_Y_RST;
      lim_r <= law_pkg::STEP_LIMIT_RST;
      trk_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        law_pkg::CFG_CENTER_X:    cx_r  <= cfg_wdata[law_pkg::COORD_W-1:0];
        law_pkg::CFG_CENTER_Y:    cy_r  <= cfg_wdata[law_pkg::COORD_W-1:0];
        law_pkg::CFG_STEP_LIMIT:  lim_r <= cfg_wdata[law_pkg::STEP_W-1:0];
        law_pkg::CFG_RADIUS_TRCK: trk_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // squared seed coordinates, registered from the centre configuration
  always_ff @(posedge clk) begin
    csq_r <= {1'b0, law_pkg::sq8(cx_r)} + {1'b0, law_pkg::sq8(cy_r)};
  end

  assign cfg.center_x        = cx_r;
  assign cfg.center_y        = cy_r;
  assign cfg.step_limit      = lim_r;
  assign cfg.radius_tracking = trk_r;
  assign cfg.center_sq       = csq_r;

  law_core #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_tvalid),
    .in_rdy    (in_tready),
    .in_action (in_tuser),
    .in_x      (in_tdata[7:0]),
    .in_y      (in_tdata[15:8]),
    .in_dir    (in_tdata[17:16]),
    .cfg       (cfg),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res)
  );

  law_gyr u_gyr (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (res_vld),
    .in_rdy (res_rdy),
    .res    (res),
    .cfg    (cfg),
    .o_vld  (out_tvalid),
    .o_rdy  (out_tready),
    .o      (o)
  );

  assign out_tuser = o.fld.status;
  assign out_tdata = {o.fld.rad, o.gyr, o.fld.count, o.fld.steps, o.fld.pos_y, o.fld.pos_x};

endmodule
